@@ rtl/core/bitmap_frame_allocator_defines.svh @@
// assertion macros for the frame allocator
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_IMPL(lbl, ante, cons, msg)
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned FC_W   = 13;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [1:0]        status_t;
  typedef logic [1:0]        cfg_idx_t;

  localparam cfg_idx_t CFG_BASE  = 2'd0;
  localparam cfg_idx_t CFG_END   = 2'd1;
  localparam cfg_idx_t CFG_COUNT = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam status_t ST_ALLOCATED = 2'd0;
  localparam status_t ST_EXHAUSTED = 2'd1;
  localparam status_t ST_FREED     = 2'd2;
  localparam status_t ST_IGNORED   = 2'd3;

endpackage

@@ rtl/core/bitmap_frame_allocator.sv @@
// first-fit frame allocator, one used bit per frame in a 64-bit-word map memory
// alloc: SCAN reads map words in order, MUL forms the address, RESP returns it; exhausted if none free
// a zero-scan-count alloc and an ignored free go straight to RESP; free: reciprocal multiply, one fixup
// one transaction at a time; the next input is taken while a result waits at the output
// after reset a clearing pass writes every map word to all used, during which no input is taken;
// state, config, scan and output-valid registers reset to zero; data registers have no reset
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator #(
  parameter int MAX_FRAMES  = 4096,
  parameter int FRAME_BYTES = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  bfa_pkg::cfg_idx_t       cfg_idx_i,
  input  logic [47:0]             cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [47:0]             s_axis_tdata,   // address
  input  logic                    s_axis_tuser,   // command
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [47:0]             m_axis_tdata,   // frame_address
  output bfa_pkg::status_t        m_axis_tuser    // status
);

  localparam int NUM_WORDS = (MAX_FRAMES + 63) / 64;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FI_W      = WA_W + 6;
  localparam int IDX_W     = $clog2(MAX_FRAMES);
  localparam int CMP_W     = ($clog2(MAX_FRAMES + 1) > 13) ? $clog2(MAX_FRAMES + 1) : 13;
  localparam longint SPAN_L = longint'(MAX_FRAMES) * longint'(FRAME_BYTES);
  localparam logic [47:0] SPAN = 48'(SPAN_L);
  localparam int DIV_W     = $clog2(SPAN_L);
  localparam longint RECIP = (longint'(1) << DIV_W) / longint'(FRAME_BYTES);
  localparam int RCP_W     = $clog2(RECIP + 1);
  localparam int PROD_W    = DIV_W + RCP_W;

  typedef enum logic [3:0] {
    INIT, IDLE, SCAN, MUL, FCHK, QEST, QMUL, QFIX, FRD, FWR, RESP
  } state_e;

  state_e                 state_q;
  bfa_pkg::addr_t         base_q, end_q, addr_q, rem_q, prod_q, diff, q_rem;
  logic [12:0]            frame_count_q;
  logic [WA_W-1:0]        scan_w_q, chk_w_q, last_w;
  logic                   chk_vld_q;
  logic [FI_W-1:0]        fidx_q, fi_free;
  logic [IDX_W-1:0]       quot_q;
  logic [PROD_W-1:0]      q_mul;
  bfa_pkg::status_t       status_q;
  logic                   m_tvalid_q;
  bfa_pkg::status_t       m_tuser_q;
  logic [47:0]            m_tdata_q;

  logic [CMP_W-1:0]       fc_ext, lim, lim_m1;
  logic [63:0]            mem [NUM_WORDS];
  logic [63:0]            rd_data_q, tail_mask, free_bits, mem_wd;
  logic [5:0]             enc;
  logic                   found, mem_we, mem_re, out_free;
  logic [WA_W-1:0]        mem_wa, mem_ra;

  // scan limit, saturated at map depth
  always_comb begin
    fc_ext = CMP_W'(frame_count_q);
    lim    = (fc_ext > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : fc_ext;
    lim_m1 = lim - CMP_W'(1);
    last_w = WA_W'(lim_m1 >> 6);
  end

  // first free frame in the checked word
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      tail_mask[b] = (6'(b) <= lim_m1[5:0]);
    end
    free_bits = ~rd_data_q & ((chk_w_q == last_w) ? tail_mask : '1);
    found     = |free_bits;
    enc       = '0;
    for (int b = 63; b >= 0; b--) begin
      if (free_bits[b]) begin
        enc = 6'(b);
      end
    end
  end

  assign diff     = addr_q - base_q;
  assign q_mul    = PROD_W'(rem_q[DIV_W-1:0]) * PROD_W'(RECIP);
  assign q_rem    = rem_q - prod_q;
  assign fi_free  = FI_W'(quot_q);
  assign out_free = !m_tvalid_q || m_axis_tready;

  // map memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = chk_w_q;
    mem_ra = scan_w_q;
    mem_wd = rd_data_q | (64'(1) << enc);
    case (state_q)
      INIT: begin
        mem_we = 1'b1;
        mem_wa = scan_w_q;
        mem_wd = '1;
      end
      SCAN: begin
        mem_re = 1'b1;
        mem_we = chk_vld_q && found;
      end
      FRD: begin
        mem_re = 1'b1;
        mem_ra = fi_free[FI_W-1:6];
      end
      FWR: begin
        mem_we = 1'b1;
        mem_wa = fi_free[FI_W-1:6];
        mem_wd = rd_data_q & ~(64'(1) << fi_free[5:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= INIT;
      base_q        <= '0;
      end_q         <= '0;
      frame_count_q <= '0;
      scan_w_q      <= '0;
      chk_vld_q     <= 1'b0;
      m_tvalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bfa_pkg::CFG_BASE:  base_q        <= cfg_wdata_i;
          bfa_pkg::CFG_END:   end_q         <= cfg_wdata_i;
          bfa_pkg::CFG_COUNT: frame_count_q <= cfg_wdata_i[12:0];
          default: begin
          end
        endcase
      end
      if ((state_q == RESP) && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        INIT: begin
          if (scan_w_q == WA_W'(NUM_WORDS - 1)) begin
            state_q <= IDLE;
          end else begin
            scan_w_q <= scan_w_q + WA_W'(1);
          end
        end
        IDLE: begin
          if (s_axis_tvalid) begin
            addr_q <= s_axis_tdata;
            if (s_axis_tuser == bfa_pkg::CMD_FREE) begin
              state_q <= FCHK;
            end else if (lim == '0) begin
              status_q <= bfa_pkg::ST_EXHAUSTED;
              state_q  <= RESP;
            end else begin
              scan_w_q  <= '0;
              chk_vld_q <= 1'b0;
              state_q   <= SCAN;
            end
          end
        end
        SCAN: begin
          chk_vld_q <= 1'b1;
          chk_w_q   <= scan_w_q;
          if (scan_w_q != last_w) begin
            scan_w_q <= scan_w_q + WA_W'(1);
          end
          if (chk_vld_q) begin
            if (found) begin
              fidx_q  <= {chk_w_q, enc};
              state_q <= MUL;
            end else if (chk_w_q == last_w) begin
              status_q <= bfa_pkg::ST_EXHAUSTED;
              state_q  <= RESP;
            end
          end
        end
        MUL: begin
          prod_q   <= 48'(fidx_q) * 48'(FRAME_BYTES);
          status_q <= bfa_pkg::ST_ALLOCATED;
          state_q  <= RESP;
        end
        FCHK: begin
          if ((addr_q < base_q) || (addr_q >= end_q) || (diff >= SPAN)) begin
            status_q <= bfa_pkg::ST_IGNORED;
            state_q  <= RESP;
          end else begin
            rem_q   <= diff;
            state_q <= QEST;
          end
        end
        // quotient estimate, low by at most one
        QEST: begin
          quot_q  <= IDX_W'(q_mul >> DIV_W);
          state_q <= QMUL;
        end
        QMUL: begin
          prod_q  <= 48'(quot_q) * 48'(FRAME_BYTES);
          state_q <= QFIX;
        end
        QFIX: begin
          if (q_rem >= 48'(FRAME_BYTES)) begin
            quot_q <= quot_q + IDX_W'(1);
          end
          state_q <= FRD;
        end
        FRD: begin
          state_q <= FWR;
        end
        FWR: begin
          status_q <= bfa_pkg::ST_FREED;
          state_q  <= RESP;
        end
        RESP: begin
          if (out_free) begin
            m_tuser_q  <= status_q;
            m_tdata_q  <= (status_q == bfa_pkg::ST_ALLOCATED) ? base_q + prod_q : '0;
            state_q    <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tdata  = m_tdata_q;

  `BFA_ASSERT_IMPL(a_init_blocks_input, state_q == INIT, !s_axis_tready, "input taken during clear")
  `BFA_ASSERT_IMPL(a_scan_in_range, (state_q == SCAN) && chk_vld_q, chk_w_q <= last_w, "scan past limit")
  `BFA_ASSERT_IMPL(a_free_index, state_q == FRD, 32'(quot_q) < 32'(MAX_FRAMES), "free index past map")
  `BFA_ASSERT_IMPL(a_addr_zero, m_axis_tvalid && (m_axis_tuser != bfa_pkg::ST_ALLOCATED), m_axis_tdata == '0, "address on non-alloc result")
  `BFA_ASSERT_NEXT(a_resp_loads, (state_q == RESP) && out_free, m_axis_tvalid && (state_q == IDLE), "result not loaded")

endmodule
